// File: design/bssgt_pkg.sv
// ----------------------------------------------------------------------------
// bssgt_pkg: shared types and constants
// Widths, status codes and state encoding for the sorted set gap tracker.
// ----------------------------------------------------------------------------
package bssgt_pkg;

    // store depth
    localparam int MAX_ENTRIES = 64;

    // fixed field widths
    localparam int IN_W    = 64;
    localparam int VAL_W   = 32;
    localparam int GAP_W   = VAL_W + 1;
    localparam int CFG_W   = 7;
    localparam int COUNT_W = 7;

    // held count must reach MAX_ENTRIES itself
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [GAP_W-1:0]        t_gap;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [LIM_W-1:0]        t_lim;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_CALC
    } t_state;

endpackage

// File: design/bssgt_ifs.sv
// ----------------------------------------------------------------------------
// bssgt_ifs: channel interfaces
// Valid/ready channels for the incoming word and the result word.
// ----------------------------------------------------------------------------
interface bssgt_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bssgt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  count;
    logic        spans_valid;
    logic [31:0] shortest_span;
    logic [31:0] longest_span;

    modport source (output valid, output status, output count, output spans_valid,
                    output shortest_span, output longest_span, input ready);
    modport sink   (input valid, input status, input count, input spans_valid,
                    input shortest_span, input longest_span, output ready);
endinterface

// File: design/bssgt_cell.sv
// ----------------------------------------------------------------------------
// bssgt_cell: one slot of the sorted chain
// Holds one value, compares it against the incoming word, shifts from its
// lower neighbor on insert and reports the gap to that neighbor.
// ----------------------------------------------------------------------------
module bssgt_cell import bssgt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_occ,
    input  logic i_tail,
    input  t_val i_word,
    input  t_val i_prev_val,
    input  logic i_prev_gt,
    output t_val o_val,
    output logic o_gt,
    output logic o_new,
    output t_gap o_left_gap
);

    t_val r_val;
    t_val n_val;
    logic r_new;
    logic n_new;
    logic w_gt;
    logic w_wen;

    // compare and pick the next slot contents
    always_comb begin
        w_gt  = i_occ && (r_val > i_word);
        w_wen = i_load && (i_occ || i_tail);
        if (i_prev_gt) begin
            n_val = i_prev_val;
        end else if (w_gt || i_tail) begin
            n_val = i_word;
        end else begin
            n_val = r_val;
        end
        n_new = w_wen && !i_prev_gt && (w_gt || i_tail);
    end

    // slot value, no reset
    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_val <= n_val;
        end
    end

    // marks the slot that took the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new <= 1'b0;
        end else begin
            r_new <= n_new;
        end
    end

    // gap to lower neighbor, sign extended so it cannot overflow
    assign o_left_gap = {r_val[VAL_W-1], r_val} - {i_prev_val[VAL_W-1], i_prev_val};
    assign o_val      = r_val;
    assign o_gt       = w_gt;
    assign o_new      = r_new;

endmodule

// File: design/bounded_sorted_set_gap_tracker.sv
// ----------------------------------------------------------------------------
// bounded_sorted_set_gap_tracker: sorted set with shortest and longest span
// Inserts 32-bit signed words into an ascending chain of cells and reports
// status, count, the smallest neighbor gap and the max minus min.
// ----------------------------------------------------------------------------
// For each word, in the accept cycle every cell compares its
// value with the word and the chain shifts to open the slot; in the next
// cycle the gaps on both sides of the new slot and the end-to-end span are
// gathered from the cells into the result register. A new word is taken
// once the result register is free or being taken, but not in the result
// cycle of the word before. Words outside the 32-bit signed range, or
// arriving while the count is at the capacity (clamped to the store depth),
// are refused and leave the store untouched; the full check wins when both
// apply. Capacity resets to zero, so it must be written before any insert.
// ----------------------------------------------------------------------------
module bounded_sorted_set_gap_tracker import bssgt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    bssgt_in_if.sink            i_item,
    bssgt_out_if.source         o_res
);

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0] r_cap;
    t_cnt             r_count;
    t_gap             r_min;
    t_status          r_status;

    logic             r_out_valid;
    t_status          r_o_status;
    logic [COUNT_W-1:0] r_o_count;
    logic             r_o_spans;
    logic [VAL_W-1:0] r_o_short;
    logic [VAL_W-1:0] r_o_long;

    logic    w_in_ready;
    logic    w_calc;
    logic    w_acc;
    logic    w_oor;
    logic    w_full;
    logic    w_ins;
    t_lim    w_limit;
    t_status w_status;
    t_val    w_word;

    logic [MAX_ENTRIES-1:0] w_occ;
    logic [MAX_ENTRIES-1:0] w_tail;
    logic [MAX_ENTRIES-1:0] w_last;
    logic [MAX_ENTRIES-1:0] w_gt;
    logic [MAX_ENTRIES-1:0] w_new;
    logic [MAX_ENTRIES-1:0] w_prev_gt;
    t_val                   w_val      [MAX_ENTRIES];
    t_val                   w_prev_val [MAX_ENTRIES];
    t_gap                   w_gap      [MAX_ENTRIES];

    t_gap             w_left;
    t_gap             w_right;
    logic             w_left_ok;
    logic             w_right_ok;
    t_val             w_top;
    t_gap             w_min1;
    t_gap             w_min2;
    logic             w_spans;
    logic [VAL_W-1:0] w_long;

    // classify the incoming word
    always_comb begin
        w_word  = t_val'(i_item.value[VAL_W-1:0]);
        w_oor   = !((&i_item.value[IN_W-1:VAL_W-1]) || !(|i_item.value[IN_W-1:VAL_W-1]));
        w_limit = (t_lim'(r_cap) > t_lim'(MAX_ENTRIES)) ? t_lim'(MAX_ENTRIES) : t_lim'(r_cap);
        w_full  = t_lim'(r_count) >= w_limit;
        if (w_full) begin
            w_status = ST_FULL;
        end else if (w_oor) begin
            w_status = ST_RANGE;
        end else begin
            w_status = ST_INSERTED;
        end
        w_acc = i_item.valid && w_in_ready;
        w_ins = w_acc && (w_status == ST_INSERTED);
    end

    // chain of cells
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        assign w_occ[gi]  = t_cnt'(gi) < r_count;
        assign w_tail[gi] = t_cnt'(gi) == r_count;
        if (gi == 0) begin : g_first
            assign w_prev_val[gi] = w_word;
            assign w_prev_gt[gi]  = 1'b0;
        end else begin : g_rest
            assign w_prev_val[gi] = w_val[gi-1];
            assign w_prev_gt[gi]  = w_gt[gi-1];
        end
        if (gi == MAX_ENTRIES - 1) begin : g_end
            assign w_last[gi] = w_occ[gi];
        end else begin : g_mid
            assign w_last[gi] = w_occ[gi] && !w_occ[gi+1];
        end

        bssgt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (w_ins),
            .i_occ      (w_occ[gi]),
            .i_tail     (w_tail[gi]),
            .i_word     (w_word),
            .i_prev_val (w_prev_val[gi]),
            .i_prev_gt  (w_prev_gt[gi]),
            .o_val      (w_val[gi]),
            .o_gt       (w_gt[gi]),
            .o_new      (w_new[gi]),
            .o_left_gap (w_gap[gi])
        );
    end

    // gather neighbor gaps of the new slot and the top value
    always_comb begin
        w_left     = '0;
        w_right    = '0;
        w_left_ok  = 1'b0;
        w_right_ok = 1'b0;
        w_top      = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_last[i]) begin
                w_top = w_top | w_val[i];
            end
            if (i > 0) begin
                if (w_new[i]) begin
                    w_left    = w_left | w_gap[i];
                    w_left_ok = 1'b1;
                end
                if (w_new[i-1] && w_occ[i]) begin
                    w_right    = w_right | w_gap[i];
                    w_right_ok = 1'b1;
                end
            end
        end
    end

    // running minimum and spans
    always_comb begin
        w_min1  = (w_left_ok && (w_left < r_min)) ? w_left : r_min;
        w_min2  = (w_right_ok && (w_right < w_min1)) ? w_right : w_min1;
        w_spans = r_count >= t_cnt'(2);
        w_long  = VAL_W'(w_top - w_val[0]);
    end

    // next state
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = w_acc ? S_CALC : S_IDLE;
            S_CALC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_in_ready = !r_out_valid || o_res.ready;
                w_calc     = 1'b0;
            end
            S_CALC: begin
                w_in_ready = 1'b0;
                w_calc     = 1'b1;
            end
            default: begin
                w_in_ready = 1'b0;
                w_calc     = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= '0;
            r_count     <= '0;
            r_min       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (w_ins) begin
                r_count <= r_count + t_cnt'(1);
            end
            if (w_calc) begin
                r_min       <= w_min2;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= w_status;
        end
        if (w_calc) begin
            r_o_status <= r_status;
            r_o_count  <= COUNT_W'(r_count);
            r_o_spans  <= w_spans;
            r_o_short  <= w_spans ? w_min2[VAL_W-1:0] : '0;
            r_o_long   <= w_spans ? w_long : '0;
        end
    end

    assign i_item.ready        = w_in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_o_status;
    assign o_res.count         = r_o_count;
    assign o_res.spans_valid   = r_o_spans;
    assign o_res.shortest_span = r_o_short;
    assign o_res.longest_span  = r_o_long;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_lim'(r_count) <= t_lim'(MAX_ENTRIES))
        else $error("held count beyond store depth");

    a_one_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_new))
        else $error("more than one cell took the word");

    a_new_on_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |=> $onehot(w_new) && (r_count == $past(r_count) + t_cnt'(1)))
        else $error("insert did not land in exactly one cell");

    a_calc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_CALC) && !i_item.ready)
        else $error("accepted word not followed by result cycle");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_CALC))
        else $error("result raised outside result cycle");

endmodule
